### hdl/mwcbp_pkg.sv
// shared types and constants of the multiword coefficient bit packer
package mwcbp_pkg;

	// coefficient part geometry
	localparam int PART_BITS = 32;
	localparam int MAX_PARTS = 32;
	localparam int PIDX_W    = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;

	// field widths
	localparam int CHUNK_W = 11;
	localparam int BYTES_W = 40;
	localparam int COUNT_W = 3;

	// one input request
	typedef struct packed {
		logic [31:0] part_word;
		logic        is_last;
	} in_item_t;

	// one result request
	typedef struct packed {
		logic [BYTES_W-1:0] packed_bytes;
		logic [COUNT_W-1:0] byte_count;
		logic               stream_end;
	} out_item_t;

	// carried bit buffer and position inside the coefficient
	typedef struct packed {
		logic [6:0]        bits;
		logic [2:0]        count;
		logic [PIDX_W-1:0] part_idx;
	} pack_state_t;

endpackage

### hdl/mwcbp_merge.sv
// combinational merge of one part into the pending bit buffer
module mwcbp_merge (
	input  logic [mwcbp_pkg::CHUNK_W-1:0] chunk_bits,
	input  mwcbp_pkg::in_item_t           item,
	input  mwcbp_pkg::pack_state_t        cur,
	output mwcbp_pkg::pack_state_t        nxt,
	output mwcbp_pkg::out_item_t          result
);
	import mwcbp_pkg::*;

	localparam logic [11:0] WMAX = 12'(PART_BITS * MAX_PARTS);

	logic [11:0] cb_ext;
	logic [11:0] w;
	logic [11:0] w_m1;
	logic [6:0]  last_idx;
	logic        last_part;
	logic [5:0]  rem_size;
	logic [5:0]  size;
	logic [31:0] word_mask;
	logic [31:0] word_m;
	logic [38:0] acc;
	logic [5:0]  cnt;
	logic [2:0]  nbytes;
	logic [5:0]  byte_shift;
	logic [39:0] byte_mask;
	logic [39:0] bytes;
	logic [38:0] tail;
	logic        flush;

	// clamp the width and locate the remainder part
	always_comb begin
		cb_ext = {1'b0, chunk_bits};
		if (cb_ext == 12'd0) begin
			w = 12'd1;
		end else if (cb_ext > WMAX) begin
			w = WMAX;
		end else begin
			w = cb_ext;
		end
		w_m1      = w - 12'd1;
		last_idx  = w_m1[11:5];
		last_part = 7'(cur.part_idx) >= last_idx;
		rem_size  = {1'b0, w_m1[4:0]} + 6'd1;
		size      = last_part ? rem_size : 6'd32;
	end

	// mask the part and append it behind the pending bits
	always_comb begin
		word_mask  = (size == 6'd32) ? '1 : ((32'd1 << size[4:0]) - 32'd1);
		word_m     = item.part_word & word_mask;
		acc        = ({7'd0, word_m} << cur.count) | {32'd0, cur.bits};
		cnt        = {3'd0, cur.count} + size;
		nbytes     = cnt[5:3];
		byte_shift = {nbytes, 3'b000};
		byte_mask  = (40'd1 << byte_shift) - 40'd1;
		bytes      = {1'b0, acc} & byte_mask;
		tail       = acc >> byte_shift;
		flush      = item.is_last && (cnt[2:0] != 3'd0);
	end

	// result and next buffer state
	always_comb begin
		result.packed_bytes = bytes;
		if (flush) begin
			result.packed_bytes = bytes | ({32'd0, tail[7:0]} << byte_shift);
		end
		result.byte_count = nbytes + {2'd0, flush};
		result.stream_end = item.is_last;
		if (item.is_last) begin
			nxt = '0;
		end else begin
			nxt.bits     = tail[6:0];
			nxt.count    = cnt[2:0];
			nxt.part_idx = last_part ? '0 : cur.part_idx + 1'b1;
		end
	end

endmodule

### hdl/multiword_coefficient_bit_packer.sv
// top level of the multiword coefficient bit packer
//
// Packs coefficients of chunk_bits bits into a dense LSB-first byte stream.
// Each coefficient arrives as 32-bit parts, least significant first; the
// last part of a coefficient carries the remainder of the width and its
// upper bits are masked off.
// Channels: in_valid/in_stall/in_data carry parts, out_valid/out_stall/
// out_data carry up to five finished bytes with a count; a request moves
// on a clock edge with valid high and stall low. cfg_valid/cfg_ready/
// cfg_data write chunk_bits (always ready); write it only while idle.
// A part passes the input register, then the merge into the result
// register. Throughput is one part per cycle unless out_stall holds a
// result, set by the combinational merge into the carried bit buffer.
// A part with is_last set flushes the partial byte zero padded and
// clears the buffer and part position for a new stream.
// Reset clears the buffer, the part position and both valids, and sets
// chunk_bits to 32. While out_stall holds a result, one more request is
// taken into the input register, after which in_stall rises.
module multiword_coefficient_bit_packer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mwcbp_pkg::CHUNK_W-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  mwcbp_pkg::in_item_t            in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output mwcbp_pkg::out_item_t           out_data
);
	import mwcbp_pkg::*;

	logic [CHUNK_W-1:0] chunk_bits_q;
	logic               valid_s1;
	in_item_t           item_s1;
	logic               out_valid_q;
	out_item_t          out_q;
	pack_state_t        state_q;
	pack_state_t        state_nxt;
	out_item_t          result;
	logic               out_free;
	logic               adv_s1;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_bits_q <= CHUNK_W'(PART_BITS);
		end else if (cfg_valid && cfg_ready) begin
			chunk_bits_q <= cfg_data;
		end
	end

	// flow control
	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// merge logic
	mwcbp_merge u_merge (
		.chunk_bits (chunk_bits_q),
		.item       (item_s1),
		.cur        (state_q),
		.nxt        (state_nxt),
		.result     (result)
	);

	// carried buffer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### hdl/mwcbp_checker.sv
// port-level checks of the multiword coefficient bit packer
module mwcbp_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_stall,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  mwcbp_pkg::out_item_t           out_data
);
	import mwcbp_pkg::*;

	// a part never yields more than five bytes
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.byte_count <= 3'd5)
		else $error("byte_count above five");

	// bytes beyond the count are zero
	a_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.byte_count < 3'd5) |->
		((out_data.packed_bytes >> {out_data.byte_count, 3'b000}) == 40'd0))
		else $error("packed_bytes has bits above byte_count");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");

	// with the result free, the input side is never stalled
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || !out_stall) |-> !in_stall)
		else $error("input stalled while result register free");

endmodule

bind multiword_coefficient_bit_packer mwcbp_checker u_mwcbp_checker (.*);

### bench/testbench.sv
// self-checking testbench of the multiword coefficient bit packer
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mwcbp_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int MAX_WIDTH  = PART_BITS * MAX_PARTS;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CHUNK_W-1:0]  cfg_data;
	logic                in_valid;
	logic                in_stall;
	in_item_t            in_data;
	logic                out_valid;
	logic                out_stall;
	out_item_t           out_data;

	// idle and stall odds in percent, changed per phase
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;

	// packer model state, follows the reset values of the block
	logic [CHUNK_W-1:0]  width_reg  = 11'd32;
	logic [6:0]          carry_bits = '0;
	logic [2:0]          carry_cnt  = '0;
	logic [4:0]          part_pos   = '0;

	out_item_t           predicted_bytes_q[$];
	int unsigned         error_count = 0;
	int unsigned         idle_cycles = 0;

	multiword_coefficient_bit_packer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// clock
	always #5 clk = ~clk;

	// merge one part into the carried bits and return the bytes it completes
	function automatic out_item_t predict_packed(in_item_t it);
		int unsigned w;
		int unsigned nparts;
		int unsigned size;
		int unsigned cnt;
		int unsigned nbytes;
		logic [63:0] acc;
		logic [63:0] word;
		logic [39:0] bytes;
		bit          last_part;
		out_item_t   res;
		w = width_reg;
		if (w < 1) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		nparts = (w + 31) / 32;
		last_part = (int'(part_pos) + 1) >= nparts;
		size = last_part ? (w - 32 * (nparts - 1)) : 32;
		word = {32'd0, it.part_word} & ((64'd1 << size) - 64'd1);
		acc = {57'd0, carry_bits} | (word << carry_cnt);
		cnt = carry_cnt + size;
		nbytes = cnt >> 3;
		bytes = 40'(acc & ((64'd1 << (8 * nbytes)) - 64'd1));
		acc = acc >> (8 * nbytes);
		cnt = cnt & 7;
		if (it.is_last) begin
			// flush the partial byte, zero padded, only if bits are left
			if (cnt > 0) begin
				bytes = bytes | (40'(acc & 64'hff) << (8 * nbytes));
				nbytes++;
			end
			acc = '0;
			cnt = 0;
			part_pos = '0;
		end else begin
			part_pos = last_part ? 5'd0 : part_pos + 5'd1;
		end
		carry_bits = acc[6:0];
		carry_cnt = 3'(cnt);
		res.packed_bytes = bytes;
		res.byte_count = 3'(nbytes);
		res.stream_end = it.is_last;
		return res;
	endfunction

	// random receiver stall
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// predict on every accepted request, track register writes
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			predicted_bytes_q.push_back(predict_packed(in_data));
		if (cfg_valid && cfg_ready)
			width_reg = cfg_data;
	end

	// compare every accepted result with the oldest prediction
	always @(posedge clk) begin
		out_item_t exp_item;
		if (out_valid && !out_stall) begin
			if (predicted_bytes_q.size() == 0) begin
				$error("unexpected result: packed_bytes %h byte_count %0d stream_end %0d",
					out_data.packed_bytes, out_data.byte_count, out_data.stream_end);
				error_count++;
			end else begin
				exp_item = predicted_bytes_q.pop_front();
				if (out_data.packed_bytes !== exp_item.packed_bytes) begin
					$error("packed_bytes: expected %h actual %h",
						exp_item.packed_bytes, out_data.packed_bytes);
					error_count++;
				end
				if (out_data.byte_count !== exp_item.byte_count) begin
					$error("byte_count: expected %0d actual %0d",
						exp_item.byte_count, out_data.byte_count);
					error_count++;
				end
				if (out_data.stream_end !== exp_item.stream_end) begin
					$error("stream_end: expected %0d actual %0d",
						exp_item.stream_end, out_data.stream_end);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted request
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// send one part, with random idle cycles ahead of it
	task automatic send_part(logic [31:0] word, logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{part_word: word, is_last: last};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// hold the sender until every predicted result has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (predicted_bytes_q.size() != 0)
			@(posedge clk);
	endtask

	// write chunk_bits while the block is idle
	task automatic set_width(logic [CHUNK_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// reset width of 32: byte aligned parts, flush with nothing left over
	task automatic test_default_width();
		send_part(32'h0000_0000, 1'b0);
		send_part(32'hffff_ffff, 1'b0);
		send_part(32'ha5a5_a5a5, 1'b0);
		send_part(32'h5a5a_5a5a, 1'b1);
	endtask

	// narrow and odd widths: masking of upper bits, padded flush
	task automatic test_narrow_widths();
		set_width(11'd1);
		send_part(32'hffff_ffff, 1'b0);
		send_part(32'hffff_fffe, 1'b0);
		send_part(32'hffff_ffff, 1'b0);
		send_part(32'hffff_ffff, 1'b1);
		// zero width behaves as one bit
		set_width(11'd0);
		send_part(32'hffff_ffff, 1'b0);
		send_part(32'hffff_ffff, 1'b1);
		// two parts, remainder part of one bit
		set_width(11'd33);
		send_part(32'hffff_ffff, 1'b0);
		send_part(32'hffff_ffff, 1'b0);
		send_part(32'h8000_0001, 1'b1);
		set_width(11'd7);
		send_part(32'h0000_007f, 1'b0);
		send_part(32'hffff_ff80, 1'b1);
	endtask

	// width shrinks while a coefficient is half sent
	task automatic test_width_change_mid();
		set_width(11'd96);
		send_part(32'h1234_5678, 1'b0);
		send_part(32'h9abc_def0, 1'b0);
		set_width(11'd40);
		send_part(32'hffff_ffff, 1'b0);
		send_part(32'hdead_beef, 1'b0);
		send_part(32'hc001_d00d, 1'b1);
	endtask

	// one run of random parts shaped as coefficient streams
	task automatic run_segment(int unsigned w, int unsigned n_items);
		int unsigned eff;
		int unsigned nparts;
		int unsigned pos;
		int unsigned flavor;
		logic [31:0] word;
		logic        last;
		eff = (w < 1) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
		nparts = (eff + 31) / 32;
		pos = 0;
		repeat (n_items) begin
			flavor = $urandom_range(0, 9);
			word = (flavor == 0) ? 32'h0 : (flavor == 1) ? 32'hffff_ffff : $urandom;
			pos++;
			if (pos >= nparts) begin
				// end of a coefficient, often the end of the stream
				pos = 0;
				last = ($urandom_range(0, 3) == 0);
			end else begin
				// broken stream: end in the middle of a coefficient
				last = ($urandom_range(0, 99) < 3);
			end
			if (last)
				pos = 0;
			send_part(word, last);
			if ($urandom_range(0, 99) == 0)
				drain_results();
		end
	endtask

	// random streams over every idling phase and a range of widths
	task automatic test_random_streams();
		int unsigned w;
		int unsigned extreme_width[4] = '{2047, 1024, 0, 1};
		for (int p = 0; p < 4; p++) begin
			drain_results();
			case (p)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 65; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 65; end
				default: begin send_idle_pct = 16; stall_pct = 16; end
			endcase
			for (int s = 0; s < 5; s++) begin
				if (s == 0)
					w = extreme_width[p];
				else if ($urandom_range(0, 4) == 0)
					w = $urandom_range(0, 2047);
				else
					w = $urandom_range(1, 72);
				set_width(w[CHUNK_W-1:0]);
				run_segment(w, 40);
			end
		end
	endtask

	// reset, directed tests, random tests, final verdict
	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_width();
		test_narrow_widths();
		test_width_change_mid();
		test_random_streams();
		drain_results();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
